FILE: hw/rtl/sensor_frame_receiver_assert.svh
// Assertion macros for the sensor frame receiver checker
`ifndef SENSOR_FRAME_RECEIVER_ASSERT_SVH
`define SENSOR_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define SFR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sensor_frame_receiver: check failed");

// next-cycle implication, no disable
`define SFR_ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("sensor_frame_receiver: check failed");

`endif

FILE: hw/rtl/sfr_pkg.sv
// Types and constants shared by the sensor frame receiver modules
package sfr_pkg;

    localparam logic [1:0] CMD_ARM  = 2'd0;
    localparam logic [1:0] CMD_BYTE = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    localparam logic [7:0]  START_BYTE      = 8'hEF;
    localparam logic [7:0]  SECOND_BYTE     = 8'h01;
    localparam logic [15:0] TIMEOUT_DEFAULT = 16'd1000;

    typedef enum logic [2:0] {
        ST_BUSY     = 3'd0,
        ST_OK       = 3'd1,
        ST_CSUM_ERR = 3'd2,
        ST_TIMEOUT  = 3'd3,
        ST_BAD_LEN  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        K_ARM  = 2'd0,
        K_BYTE = 2'd1,
        K_TICK = 2'd2
    } t_kind;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  byte_value;
        logic [16:0] byte_index;
        logic        last;
        t_status     status;
    } t_out_item;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       is_start;
        logic       is_second;
    } t_op;

endpackage

FILE: hw/rtl/sfr_front.sv
// Front end: accept items, classify them, queue valid ones for back end
module sfr_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  sfr_pkg::t_in_item i_item,
    output logic            o_op_valid,
    output sfr_pkg::t_op    o_op,
    input  logic            i_op_take
);

    sfr_pkg::t_op r_q [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         n_wp, n_rp;
    logic [1:0]   n_cnt;
    logic         accept, keep;
    sfr_pkg::t_op op_in;

    assign full       = (r_cnt == 2'd2);
    assign accept     = push && !full;
    assign o_op_valid = (r_cnt != 2'd0);
    assign o_op       = r_q[r_rp];

    always_comb begin
        op_in.data      = i_item.rx_byte;
        op_in.is_start  = (i_item.rx_byte == sfr_pkg::START_BYTE);
        op_in.is_second = (i_item.rx_byte == sfr_pkg::SECOND_BYTE);
        op_in.kind      = sfr_pkg::K_ARM;
        keep            = 1'b1;
        unique case (i_item.command)
            sfr_pkg::CMD_ARM:  op_in.kind = sfr_pkg::K_ARM;
            sfr_pkg::CMD_BYTE: op_in.kind = sfr_pkg::K_BYTE;
            sfr_pkg::CMD_TICK: op_in.kind = sfr_pkg::K_TICK;
            default:           keep       = 1'b0;
        endcase
    end

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (accept && keep) begin
            n_wp = ~r_wp;
        end
        if (i_op_take && o_op_valid) begin
            n_rp = ~r_rp;
        end
        n_cnt = r_cnt + 2'(accept && keep) - 2'(i_op_take && o_op_valid);
    end

    always_ff @(posedge i_clk) begin
        if (accept && keep) begin
            r_q[r_wp] <= op_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

FILE: hw/rtl/sfr_back.sv
// Back end: frame state, checksum, timer and the result queue
module sfr_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_wdata,
    input  logic              i_op_valid,
    input  sfr_pkg::t_op      i_op,
    output logic              o_op_take,
    output logic              empty,
    input  logic              pop,
    output sfr_pkg::t_out_item o_result
);

    logic        r_armed, n_armed;
    logic [16:0] r_count, n_count;
    logic [15:0] r_len, n_len;
    logic [15:0] r_sum, n_sum;
    logic [7:0]  r_chk, n_chk;
    logic [15:0] r_elapsed, n_elapsed;
    logic [15:0] r_timeout;

    sfr_pkg::t_out_item r_oq [2];
    logic               r_owp, r_orp;
    logic [1:0]         r_ocnt;
    logic               res_valid, out_pop;
    sfr_pkg::t_out_item res;

    logic [16:0] idx;
    logic [7:0]  b;
    logic [15:0] len_eff;
    logic [16:0] lim6, lim7, lim8;
    logic [15:0] tick_next;

    assign o_op_take = i_op_valid && (r_ocnt != 2'd2);
    assign empty     = (r_ocnt == 2'd0);
    assign out_pop   = pop && !empty;
    assign o_result  = r_oq[r_orp];

    assign idx       = r_count;
    assign b         = i_op.data;
    assign len_eff   = (r_count == 17'd8) ? {r_len[15:8], b} : r_len;
    assign lim6      = {1'b0, len_eff} + 17'd6;
    assign lim7      = {1'b0, r_len} + 17'd7;
    assign lim8      = {1'b0, r_len} + 17'd8;
    assign tick_next = (r_elapsed == 16'hFFFF) ? r_elapsed : r_elapsed + 16'd1;

    always_comb begin
        n_armed   = r_armed;
        n_count   = r_count;
        n_len     = r_len;
        n_sum     = r_sum;
        n_chk     = r_chk;
        n_elapsed = r_elapsed;
        res_valid = 1'b0;
        res       = '0;
        if (o_op_take) begin
            unique case (i_op.kind)
                sfr_pkg::K_ARM: begin
                    n_armed   = 1'b1;
                    n_count   = '0;
                    n_len     = '0;
                    n_sum     = '0;
                    n_chk     = '0;
                    n_elapsed = '0;
                end
                sfr_pkg::K_BYTE: begin
                    if (r_armed) begin
                        if (idx == 17'd0) begin
                            if (i_op.is_start) begin
                                n_count        = 17'd1;
                                n_elapsed      = '0;
                                res_valid      = 1'b1;
                                res.byte_value = b;
                            end
                        end else if (idx == 17'd1 && !i_op.is_second) begin
                            n_count   = '0;
                            n_len     = '0;
                            n_sum     = '0;
                            n_chk     = '0;
                            n_elapsed = '0;
                            if (i_op.is_start) begin
                                n_count        = 17'd1;
                                res_valid      = 1'b1;
                                res.byte_value = b;
                            end
                        end else begin
                            if (idx == 17'd7) begin
                                n_len = {b, 8'h00};
                            end else if (idx == 17'd8) begin
                                n_len = len_eff;
                            end
                            res_valid      = 1'b1;
                            res.byte_value = b;
                            res.byte_index = idx;
                            if (idx == 17'd8 && len_eff < 16'd2) begin
                                n_armed    = 1'b0;
                                n_count    = '0;
                                n_len      = '0;
                                n_sum      = '0;
                                n_chk      = '0;
                                n_elapsed  = '0;
                                res.last   = 1'b1;
                                res.status = sfr_pkg::ST_BAD_LEN;
                            end else begin
                                if (idx >= 17'd6 && (idx <= 17'd8 || idx <= lim6)) begin
                                    n_sum = r_sum + {8'h00, b};
                                end
                                if (idx >= 17'd9 && idx == lim7) begin
                                    n_chk = b;
                                end
                                if (idx >= 17'd9 && idx == lim8) begin
                                    n_armed    = 1'b0;
                                    n_count    = '0;
                                    n_len      = '0;
                                    n_sum      = '0;
                                    n_chk      = '0;
                                    n_elapsed  = '0;
                                    res.last   = 1'b1;
                                    res.status = ({r_chk, b} == r_sum) ? sfr_pkg::ST_OK
                                                                       : sfr_pkg::ST_CSUM_ERR;
                                end else begin
                                    n_count = idx + 17'd1;
                                end
                            end
                        end
                    end
                end
                sfr_pkg::K_TICK: begin
                    if (r_armed) begin
                        n_elapsed = tick_next;
                        if (tick_next >= r_timeout) begin
                            n_armed    = 1'b0;
                            n_count    = '0;
                            n_len      = '0;
                            n_sum      = '0;
                            n_chk      = '0;
                            n_elapsed  = '0;
                            res_valid  = 1'b1;
                            res.last   = 1'b1;
                            res.status = sfr_pkg::ST_TIMEOUT;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_oq[r_owp] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed   <= 1'b0;
            r_count   <= '0;
            r_len     <= '0;
            r_sum     <= '0;
            r_chk     <= '0;
            r_elapsed <= '0;
            r_timeout <= sfr_pkg::TIMEOUT_DEFAULT;
            r_owp     <= 1'b0;
            r_orp     <= 1'b0;
            r_ocnt    <= 2'd0;
        end else begin
            r_armed   <= n_armed;
            r_count   <= n_count;
            r_len     <= n_len;
            r_sum     <= n_sum;
            r_chk     <= n_chk;
            r_elapsed <= n_elapsed;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (res_valid) begin
                r_owp <= ~r_owp;
            end
            if (out_pop) begin
                r_orp <= ~r_orp;
            end
            r_ocnt <= r_ocnt + 2'(res_valid) - 2'(out_pop);
        end
    end

endmodule

FILE: hw/rtl/sensor_frame_receiver.sv
// Top level of the sensor frame receiver
//
//   channel   direction  handshake              payload
//   input     in         push / full            i_item   (command, rx_byte)
//   result    out        empty / pop            o_result (byte_value, byte_index, last, status)
//   config    in         i_cfg_we               i_cfg_wdata (timeout_ticks)
//
// One item per cycle while full is low; an item is queued, then its result is queued.
// The front queue and the result queue hold two items each and set the stall points.
// Reset clears both queues, the frame state and the timer; timeout_ticks returns to 1000.
// Pop held low stops input only once both queues fill.
module sensor_frame_receiver (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  sfr_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output sfr_pkg::t_out_item o_result,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata
);

    logic         op_valid, op_take;
    sfr_pkg::t_op op;

    sfr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .o_op_valid (op_valid),
        .o_op       (op),
        .i_op_take  (op_take)
    );

    sfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op_valid  (op_valid),
        .i_op        (op),
        .o_op_take   (op_take),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

endmodule

FILE: hw/rtl/sfr_checker.sv
// Port-level checks for the sensor frame receiver, bound to the top level
`include "sensor_frame_receiver_assert.svh"

module sfr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               full,
    input logic               empty,
    input sfr_pkg::t_out_item o_result
);

    `SFR_ASSERT_NEXT(a_reset_clears, i_clk, !i_rst_n, empty && !full)

    `SFR_ASSERT_NOW(a_last_means_done, i_clk, i_rst_n, !empty,
        o_result.last == (o_result.status != sfr_pkg::ST_BUSY))

    `SFR_ASSERT_NOW(a_timeout_shape, i_clk, i_rst_n,
        !empty && o_result.status == sfr_pkg::ST_TIMEOUT,
        o_result.byte_value == 8'd0 && o_result.byte_index == 17'd0)

    `SFR_ASSERT_NOW(a_first_is_start, i_clk, i_rst_n,
        !empty && o_result.byte_index == 17'd0 && !o_result.last,
        o_result.byte_value == sfr_pkg::START_BYTE)

endmodule

bind sensor_frame_receiver sfr_checker u_sfr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .full        (full),
    .empty       (empty),
    .o_result    (o_result)
);

FILE: verif/sensor_frame_receiver_tb.sv
// Testbench for the sensor frame receiver: directed and random reply frames checked by a predictor
module sensor_frame_receiver_tb;
    import sfr_pkg::*;

    localparam logic [1:0] CMD_SPARE     = 2'd3;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         CYCLE_LIMIT   = 1_000_000;

    typedef enum logic [1:0] {
        BY_MODEL     = 2'd0,
        TYPED_NONE   = 2'd1,
        TYPED_RESULT = 2'd2
    } t_check_kind;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  data;
        t_check_kind how;
        t_out_item   want;
    } t_dir_row;

    typedef struct packed {
        t_check_kind how;
        t_out_item   want;
    } t_issue_note;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        push        = 1'b0;
    logic        pop         = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    t_in_item    i_item      = '0;
    logic        full;
    logic        empty;
    t_out_item   o_result;

    logic [15:0] rx_timeout   = TIMEOUT_DEFAULT;
    logic        rx_armed     = 1'b0;
    logic [16:0] rx_count     = '0;
    logic [15:0] rx_length    = '0;
    logic [15:0] rx_sum       = '0;
    logic [7:0]  rx_csum_high = '0;
    logic [15:0] rx_elapsed   = '0;

    t_out_item   expected_replies[$];
    t_issue_note issue_notes[$];
    t_dir_row    dir_rows[$];

    int errors          = 0;
    int items_accepted  = 0;
    int worked_items    = 0;
    int results_checked = 0;
    int ends_seen[8]    = '{default: 0};
    int cycle_count     = 0;
    int pop_hold        = 0;
    bit pop_calm        = 1'b0;
    bit send_calm       = 1'b0;

    sensor_frame_receiver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_out_item reply(logic [7:0] v, logic [16:0] idx, logic l, t_status s);
        t_out_item r;
        r.byte_value = v;
        r.byte_index = idx;
        r.last       = l;
        r.status     = s;
        return r;
    endfunction

    function automatic t_dir_row step_row(logic [1:0] cmd, logic [7:0] data, t_check_kind how,
                                          t_out_item want);
        t_dir_row row;
        row.command = cmd;
        row.data    = data;
        row.how     = how;
        row.want    = want;
        return row;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return 16'($urandom_range(2, 10));
        if (r < 98) return 16'($urandom_range(11, 80));
        return 16'($urandom_range(250, 320));
    endfunction

    function automatic void clear_frame();
        rx_count     = '0;
        rx_length    = '0;
        rx_sum       = '0;
        rx_csum_high = '0;
    endfunction

    function automatic void close_frame();
        rx_armed = 1'b0;
        clear_frame();
        rx_elapsed = '0;
    endfunction

    function automatic void predict_reply(input t_in_item it, output bit has, output t_out_item r);
        int unsigned idx;
        int unsigned len;
        logic [7:0]  b;
        has = 1'b0;
        r   = '0;
        idx = rx_count;
        len = rx_length;
        b   = it.rx_byte;
        if (it.command == CMD_ARM) begin
            rx_armed = 1'b1;
            clear_frame();
            rx_elapsed = '0;
            return;
        end
        if (!rx_armed) return;
        if (it.command == CMD_TICK) begin
            if (rx_elapsed != 16'hFFFF) rx_elapsed++;
            if (rx_elapsed >= rx_timeout) begin
                close_frame();
                has = 1'b1;
                r   = reply(8'h00, 17'd0, 1'b1, ST_TIMEOUT);
            end
            return;
        end
        if (it.command != CMD_BYTE) return;
        if (idx == 0) begin
            if (b != START_BYTE) return;
            rx_count   = 17'd1;
            rx_elapsed = '0;
            has        = 1'b1;
            r          = reply(b, 17'd0, 1'b0, ST_BUSY);
            return;
        end
        if (idx == 1 && b != SECOND_BYTE) begin
            clear_frame();
            rx_elapsed = '0;
            if (b == START_BYTE) begin
                rx_count = 17'd1;
                has      = 1'b1;
                r        = reply(b, 17'd0, 1'b0, ST_BUSY);
            end
            return;
        end
        if (idx == 7) begin
            rx_length = {b, 8'h00};
        end else if (idx == 8) begin
            rx_length = rx_length | b;
            len       = rx_length;
        end
        has = 1'b1;
        if (idx == 8 && len < 2) begin
            close_frame();
            r = reply(b, 17'd8, 1'b1, ST_BAD_LEN);
            return;
        end
        if (idx >= 6 && (idx <= 8 || idx <= 6 + len)) rx_sum += b;
        if (idx >= 9 && idx == 7 + len) rx_csum_high = b;
        if (idx >= 9 && idx == 8 + len) begin
            r = reply(b, idx[16:0], 1'b1, ({rx_csum_high, b} == rx_sum) ? ST_OK : ST_CSUM_ERR);
            close_frame();
            return;
        end
        rx_count = 17'(idx + 1);
        r        = reply(b, idx[16:0], 1'b0, ST_BUSY);
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("%0t error %s: got %0d, want %0d", $time, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_issue_note note;
        bit          has;
        t_out_item   want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("sensor_frame_receiver: mismatch");
            $finish;
        end
        if (i_rst_n && push && !full) begin
            note = issue_notes.pop_front();
            predict_reply(i_item, has, want);
            if (has || i_item.command == CMD_ARM) worked_items++;
            if (note.how == TYPED_NONE) begin
                has = 1'b0;
            end else if (note.how == TYPED_RESULT) begin
                has  = 1'b1;
                want = note.want;
            end
            if (has) expected_replies.push_back(want);
            items_accepted++;
        end
        if (i_rst_n && pop && !empty) begin
            if (expected_replies.size() == 0) begin
                report("result with none expected, byte_index", o_result.byte_index, 0);
            end else begin
                want = expected_replies.pop_front();
                results_checked++;
                if (want.last) ends_seen[want.status]++;
                if (o_result.byte_value !== want.byte_value)
                    report("byte_value", o_result.byte_value, want.byte_value);
                if (o_result.byte_index !== want.byte_index)
                    report("byte_index", o_result.byte_index, want.byte_index);
                if (o_result.last !== want.last)
                    report("last", o_result.last, want.last);
                if (o_result.status !== want.status)
                    report("status", o_result.status, want.status);
            end
        end
        if (pop_hold > 0) begin
            pop <= 1'b0;
            pop_hold--;
        end else begin
            pop <= 1'b1;
            if (!pop_calm && $urandom_range(0, 99) < 30) pop_hold = pick_gap();
        end
        if ($urandom_range(0, 199) == 0) pop_calm = !pop_calm;
    end

    task automatic issue(input t_in_item it, input t_issue_note note);
        int gap;
        gap = send_calm ? 0 : pick_gap();
        if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
        if (gap > 0) begin
            push   <= 1'b0;
            i_item <= t_in_item'(10'($urandom));
            repeat (gap) @(posedge i_clk);
        end
        issue_notes.push_back(note);
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
    endtask

    task automatic send(input logic [1:0] cmd, input logic [7:0] data);
        t_in_item    it;
        t_issue_note note;
        it.command  = cmd;
        it.rx_byte  = data;
        note.how    = BY_MODEL;
        note.want   = '0;
        issue(it, note);
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_timeout(input logic [15:0] ticks);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= ticks;
        @(posedge i_clk);
        rx_timeout = ticks;
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_frame(input logic [15:0] len, input bit good_sum, input int keep);
        logic [7:0]  bytes[$];
        logic [15:0] sum;
        int          total;
        int          r;
        bytes = {};
        bytes.push_back(START_BYTE);
        bytes.push_back(SECOND_BYTE);
        repeat (5) bytes.push_back(8'($urandom));
        bytes.push_back(len[15:8]);
        bytes.push_back(len[7:0]);
        if (len >= 2) begin
            repeat (len - 2) bytes.push_back(8'($urandom));
            sum = '0;
            for (int k = 6; k <= 6 + len; k++) sum += bytes[k];
            if (!good_sum) sum ^= 16'(1 << $urandom_range(0, 15));
            bytes.push_back(sum[15:8]);
            bytes.push_back(sum[7:0]);
        end
        total = (keep >= 0 && keep < bytes.size()) ? keep : bytes.size();
        for (int k = 0; k < total; k++) begin
            r = $urandom_range(0, 99);
            if (r < 3) send(CMD_TICK, 8'($urandom));
            else if (r < 5) send(CMD_SPARE, 8'($urandom));
            send(CMD_BYTE, bytes[k]);
        end
    endtask

    task automatic random_episode();
        int          r;
        int          n;
        logic [7:0]  b;
        logic [15:0] len;
        r = $urandom_range(0, 99);
        send(CMD_ARM, 8'($urandom));
        if (r < 55) begin
            repeat ($urandom_range(0, 2)) begin
                b = 8'($urandom);
                if (b == START_BYTE) b = 8'h00;
                send(CMD_BYTE, b);
            end
            send_frame(pick_length(), $urandom_range(0, 99) < 85, -1);
        end else if (r < 65) begin
            send(CMD_BYTE, START_BYTE);
            b = 8'($urandom);
            if (b == SECOND_BYTE || $urandom_range(0, 1) == 0) b = START_BYTE;
            send(CMD_BYTE, b);
            send_frame(pick_length(), $urandom_range(0, 99) < 85, -1);
        end else if (r < 73) begin
            send_frame(16'($urandom_range(0, 1)), 1'b1, -1);
        end else if (r < 83) begin
            if ($urandom_range(0, 1)) send_frame(pick_length(), 1'b1, $urandom_range(1, 8));
            n = (rx_timeout <= 40) ? rx_timeout + $urandom_range(0, 2) : $urandom_range(1, 5);
            repeat (n) send(CMD_TICK, 8'($urandom));
        end else if (r < 91) begin
            len = {8'($urandom_range(1, 255)), 8'($urandom)};
            send_frame(len, 1'b1, $urandom_range(9, 14));
        end else begin
            repeat ($urandom_range(3, 12)) send(2'($urandom_range(0, 3)), 8'($urandom));
        end
    endtask

    initial begin
        t_in_item    it;
        t_issue_note note;
        logic [15:0] phase_timeout[4];
        int          phase_budget[4];
        int          target;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        dir_rows = '{
            step_row(CMD_BYTE,  8'hEF, TYPED_NONE,   '0),
            step_row(CMD_TICK,  8'h00, TYPED_NONE,   '0),
            step_row(CMD_SPARE, 8'hFF, TYPED_NONE,   '0),
            step_row(CMD_ARM,   8'h00, TYPED_NONE,   '0),
            step_row(CMD_BYTE,  8'h00, TYPED_NONE,   '0),
            step_row(CMD_BYTE,  8'hEF, TYPED_RESULT, reply(8'hEF, 17'd0, 1'b0, ST_BUSY)),
            step_row(CMD_BYTE,  8'hEF, TYPED_RESULT, reply(8'hEF, 17'd0, 1'b0, ST_BUSY)),
            step_row(CMD_BYTE,  8'hFF, TYPED_NONE,   '0),
            step_row(CMD_TICK,  8'hFF, TYPED_NONE,   '0),
            step_row(CMD_TICK,  8'h00, TYPED_RESULT, reply(8'h00, 17'd0, 1'b1, ST_TIMEOUT)),
            step_row(CMD_BYTE,  8'hEF, TYPED_NONE,   '0),
            step_row(CMD_ARM,   8'hFF, TYPED_NONE,   '0),
            step_row(CMD_TICK,  8'h00, BY_MODEL,     '0),
            step_row(CMD_ARM,   8'h00, TYPED_NONE,   '0),
            step_row(CMD_TICK,  8'h00, TYPED_NONE,   '0),
            step_row(CMD_BYTE,  8'hEF, TYPED_RESULT, reply(8'hEF, 17'd0, 1'b0, ST_BUSY)),
            step_row(CMD_TICK,  8'h00, BY_MODEL,     '0),
            step_row(CMD_BYTE,  8'h01, TYPED_RESULT, reply(8'h01, 17'd1, 1'b0, ST_BUSY)),
            step_row(CMD_BYTE,  8'hFF, BY_MODEL,     '0),
            step_row(CMD_BYTE,  8'h00, BY_MODEL,     '0),
            step_row(CMD_BYTE,  8'hFF, BY_MODEL,     '0),
            step_row(CMD_BYTE,  8'h00, BY_MODEL,     '0),
            step_row(CMD_SPARE, 8'h00, TYPED_NONE,   '0),
            step_row(CMD_BYTE,  8'hFF, BY_MODEL,     '0),
            step_row(CMD_BYTE,  8'h00, BY_MODEL,     '0),
            step_row(CMD_BYTE,  8'h01, TYPED_RESULT, reply(8'h01, 17'd8, 1'b1, ST_BAD_LEN)),
            step_row(CMD_BYTE,  8'hEF, TYPED_NONE,   '0)
        };

        set_timeout(16'd2);
        foreach (dir_rows[k]) begin
            it.command = dir_rows[k].command;
            it.rx_byte = dir_rows[k].data;
            note.how   = dir_rows[k].how;
            note.want  = dir_rows[k].want;
            issue(it, note);
        end
        drain();

        phase_timeout = '{16'hFFFF, 16'd1, 16'($urandom_range(3, 24)), TIMEOUT_DEFAULT};
        phase_budget  = '{230, 100, 310, 240};
        for (int p = 0; p < 4; p++) begin
            set_timeout(phase_timeout[p]);
            target = worked_items + phase_budget[p];
            while (worked_items < target) random_episode();
            drain();
        end

        $display("run covered %0d items accepted, %0d results checked over five timeout settings",
                 items_accepted, results_checked);
        $display("frame ends seen: %0d ok, %0d checksum error, %0d timeout, %0d bad length",
                 ends_seen[ST_OK], ends_seen[ST_CSUM_ERR], ends_seen[ST_TIMEOUT],
                 ends_seen[ST_BAD_LEN]);
        if (errors == 0) begin
            $display("sensor_frame_receiver: match");
        end else begin
            $display("sensor_frame_receiver: mismatch");
        end
        $finish;
    end

endmodule
